@@ hdl/ray_triangle_intersect_macros.svh @@
// Assertion macros shared by the ray-triangle checker.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define RTI_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ray_triangle_intersect check failed");

// Check that a consequent holds whenever an antecedent holds.
`define RTI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_triangle_intersect check failed");

`endif

@@ hdl/rti_pkg.sv @@
// Types and constants shared by the ray-triangle intersection pipeline.
`default_nettype none

package rti_pkg;

    localparam int unsigned FRONT_STAGES = 6;
    localparam int unsigned DIV_STEPS    = 33;
    localparam int unsigned BACK_STAGES  = 3;
    localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

    typedef struct packed {
        logic [47:0] ray_origin;
        logic [47:0] ray_direction;
        logic [47:0] vertex_a;
        logic [47:0] vertex_b;
        logic [47:0] vertex_c;
    } query_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
        logic [47:0]        hit_point;
    } result_t;

    // One word in flight through the divider.
    typedef struct packed {
        logic [53:0] rem;
        logic [53:0] den;
        logic [32:0] feed;
        logic [32:0] quo;
        logic        neg;
        logic        ovf;
        logic        hit;
        logic [47:0] origin;
        logic [47:0] direction;
    } div_t;

endpackage

`default_nettype wire

@@ hdl/rti_front.sv @@
// Edge, cross product and dot product stages with the inside test.
`default_nettype none

module rti_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           valid_in,
    input  wire rti_pkg::query_t query_in,
    output logic                valid_out,
    output rti_pkg::div_t       div_out
);

    logic [5:0] valid_reg;
    logic [5:0] valid_next;

    // stage 1
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [16:0] s_reg  [3];
    logic signed [16:0] e1_next [3];
    logic signed [16:0] e2_next [3];
    logic signed [16:0] s_next  [3];
    logic [47:0] org1_reg, dir1_reg;

    // stage 2
    logic signed [33:0] pa_reg [3];
    logic signed [33:0] pb_reg [3];
    logic signed [33:0] qa_reg [3];
    logic signed [33:0] qb_reg [3];
    logic signed [33:0] pa_next [3];
    logic signed [33:0] pb_next [3];
    logic signed [33:0] qa_next [3];
    logic signed [33:0] qb_next [3];
    logic signed [16:0] e1b_reg [3];
    logic signed [16:0] e2b_reg [3];
    logic signed [16:0] sb_reg  [3];
    logic [47:0] org2_reg, dir2_reg;

    // stage 3
    logic signed [34:0] p_reg [3];
    logic signed [34:0] q_reg [3];
    logic signed [16:0] e1c_reg [3];
    logic signed [16:0] e2c_reg [3];
    logic signed [16:0] sc_reg  [3];
    logic [47:0] org3_reg, dir3_reg;

    // stage 4
    logic signed [51:0] mdet_reg [3];
    logic signed [51:0] mu_reg   [3];
    logic signed [51:0] mv_reg   [3];
    logic signed [51:0] mt_reg   [3];
    logic [47:0] org4_reg, dir4_reg;

    // stage 5
    logic signed [55:0] det_reg, un_reg, vn_reg, tn_reg;
    logic signed [55:0] det_next, un_next, vn_next, tn_next;
    logic [47:0] org5_reg, dir5_reg;

    // stage 6
    rti_pkg::div_t div_reg;
    rti_pkg::div_t div_next;

    assign valid_next = {valid_reg[4:0], valid_in};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = 17'(signed'(query_in.vertex_b[16*i +: 16]))
                       - 17'(signed'(query_in.vertex_a[16*i +: 16]));
            e2_next[i] = 17'(signed'(query_in.vertex_c[16*i +: 16]))
                       - 17'(signed'(query_in.vertex_a[16*i +: 16]));
            s_next[i]  = 17'(signed'(query_in.ray_origin[16*i +: 16]))
                       - 17'(signed'(query_in.vertex_a[16*i +: 16]));
        end
    end

    // Cross products p = d x e2 and q = s x e1, one product per term.
    always_comb
    begin
        logic signed [16:0] dv [3];
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = 17'(signed'(dir1_reg[16*i +: 16]));
        end
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = dv[(i+1)%3] * e2_reg[(i+2)%3];
            pb_next[i] = dv[(i+2)%3] * e2_reg[(i+1)%3];
            qa_next[i] = s_reg[(i+1)%3] * e1_reg[(i+2)%3];
            qb_next[i] = s_reg[(i+2)%3] * e1_reg[(i+1)%3];
        end
    end

    always_comb
    begin
        det_next = 56'(mdet_reg[0]) + 56'(mdet_reg[1]) + 56'(mdet_reg[2]);
        un_next  = 56'(mu_reg[0]) + 56'(mu_reg[1]) + 56'(mu_reg[2]);
        vn_next  = 56'(mv_reg[0]) + 56'(mv_reg[1]) + 56'(mv_reg[2]);
        tn_next  = 56'(mt_reg[0]) + 56'(mt_reg[1]) + 56'(mt_reg[2]);
    end

    // Flip signs so the determinant is positive, then test the barycentrics.
    always_comb
    begin
        logic               neg_det;
        logic signed [55:0] det_a, un_a, vn_a, tn_a;
        logic signed [56:0] uv_sum;
        logic [53:0]        mag;
        neg_det = det_reg[55];
        det_a   = neg_det ? -det_reg : det_reg;
        un_a    = neg_det ? -un_reg  : un_reg;
        vn_a    = neg_det ? -vn_reg  : vn_reg;
        tn_a    = neg_det ? -tn_reg  : tn_reg;
        uv_sum  = 57'(un_a) + 57'(vn_a);
        mag     = tn_a[55] ? 54'(-tn_a) : tn_a[53:0];

        div_next.hit = (det_reg != '0) && !un_a[55] && (un_a <= det_a)
                     && !vn_a[55] && (uv_sum <= 57'(det_a));
        div_next.neg = tn_a[55];
        div_next.den = det_a[53:0];
        div_next.ovf = {16'b0, mag} >= {det_a[53:0], 16'b0};
        div_next.rem = {16'b0, mag[53:16]};
        div_next.feed = {mag[15:0], 17'b0};
        div_next.quo = '0;
        div_next.origin = org5_reg;
        div_next.direction = dir5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i]  <= e1_next[i];
            e2_reg[i]  <= e2_next[i];
            s_reg[i]   <= s_next[i];
            pa_reg[i]  <= pa_next[i];
            pb_reg[i]  <= pb_next[i];
            qa_reg[i]  <= qa_next[i];
            qb_reg[i]  <= qb_next[i];
            e1b_reg[i] <= e1_reg[i];
            e2b_reg[i] <= e2_reg[i];
            sb_reg[i]  <= s_reg[i];
            p_reg[i]   <= 35'(pa_reg[i]) - 35'(pb_reg[i]);
            q_reg[i]   <= 35'(qa_reg[i]) - 35'(qb_reg[i]);
            e1c_reg[i] <= e1b_reg[i];
            e2c_reg[i] <= e2b_reg[i];
            sc_reg[i]  <= sb_reg[i];
            mdet_reg[i] <= e1c_reg[i] * p_reg[i];
            mu_reg[i]   <= sc_reg[i] * p_reg[i];
            mv_reg[i]   <= 17'(signed'(dir3_reg[16*i +: 16])) * q_reg[i];
            mt_reg[i]   <= e2c_reg[i] * q_reg[i];
        end
        org1_reg <= query_in.ray_origin;
        dir1_reg <= query_in.ray_direction;
        org2_reg <= org1_reg;
        dir2_reg <= dir1_reg;
        org3_reg <= org2_reg;
        dir3_reg <= dir2_reg;
        org4_reg <= org3_reg;
        dir4_reg <= dir3_reg;
        org5_reg <= org4_reg;
        dir5_reg <= dir4_reg;
        det_reg  <= det_next;
        un_reg   <= un_next;
        vn_reg   <= vn_next;
        tn_reg   <= tn_next;
        div_reg  <= div_next;
    end

    assign valid_out = valid_reg[5];
    assign div_out   = div_reg;

endmodule

`default_nettype wire

@@ hdl/rti_div_step.sv @@
// One restoring division step: one quotient bit per stage.
`default_nettype none

module rti_div_step
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    input  wire rti_pkg::div_t div_in,
    output logic               valid_out,
    output rti_pkg::div_t      div_out
);

    logic          valid_reg;
    rti_pkg::div_t div_reg;
    rti_pkg::div_t div_next;

    always_comb
    begin
        logic [54:0] trial;
        logic        fits;
        trial = {div_in.rem, div_in.feed[32]};
        fits  = trial >= {1'b0, div_in.den};
        div_next      = div_in;
        div_next.rem  = fits ? 54'(trial - {1'b0, div_in.den}) : trial[53:0];
        div_next.feed = {div_in.feed[31:0], 1'b0};
        div_next.quo  = {div_in.quo[31:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign valid_out = valid_reg;
    assign div_out   = div_reg;

endmodule

`default_nettype wire

@@ hdl/rti_back.sv @@
// Rounding and saturation of t, then the hit point.
`default_nettype none

module rti_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid_in,
    input  wire rti_pkg::div_t div_in,
    output logic               done,
    output rti_pkg::result_t   result
);

    logic [2:0] valid_reg;

    logic signed [31:0] t1_reg, t2_reg;
    logic signed [31:0] t_next;
    logic               hit1_reg, hit2_reg;
    logic [47:0]        org1_reg, org2_reg, dir1_reg;
    logic signed [47:0] prod_reg [3];

    rti_pkg::result_t result_reg;
    rti_pkg::result_t result_next;

    // Round half away from zero on the extra quotient bit, then clamp.
    always_comb
    begin
        logic [32:0] res;
        res = {1'b0, div_in.quo[32:1]} + 33'(div_in.quo[0]);
        if (div_in.ovf)
        begin
            t_next = div_in.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else if (!div_in.neg)
        begin
            t_next = (res > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : res[31:0];
        end
        else
        begin
            t_next = (res > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(33'd0 - res);
        end
    end

    always_comb
    begin
        logic signed [49:0] sum;
        logic signed [33:0] c;
        result_next.hit      = hit2_reg;
        result_next.distance = hit2_reg ? t2_reg : '0;
        result_next.hit_point = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum = {{18{org2_reg[16*i+15]}}, org2_reg[16*i +: 16], 16'b0}
                + {{2{prod_reg[i][47]}}, prod_reg[i]} + 50'sd32768;
            c = sum[49:16];
            if (!hit2_reg)
            begin
                result_next.hit_point[16*i +: 16] = '0;
            end
            else if (c > 34'sd32767)
            begin
                result_next.hit_point[16*i +: 16] = 16'h7FFF;
            end
            else if (c < -34'sd32768)
            begin
                result_next.hit_point[16*i +: 16] = 16'h8000;
            end
            else
            begin
                result_next.hit_point[16*i +: 16] = c[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= t_next;
        hit1_reg <= div_in.hit;
        org1_reg <= div_in.origin;
        dir1_reg <= div_in.direction;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= signed'(dir1_reg[16*i +: 16]) * t1_reg;
        end
        t2_reg     <= t1_reg;
        hit2_reg   <= hit1_reg;
        org2_reg   <= org1_reg;
        result_reg <= result_next;
    end

    assign done   = valid_reg[2];
    assign result = result_reg;

endmodule

`default_nettype wire

@@ hdl/ray_triangle_intersect.sv @@
// Top level of the pipelined ray-triangle intersection test.
`default_nettype none

// Moller-Trumbore ray-triangle test, fully pipelined. Raise start with a
// query word (ray origin, direction and three vertices, packed signed Q8.8)
// and it is taken on that clock edge; busy never rises, so one word may
// enter every cycle. Each word produces exactly one result word, shown for
// a single cycle with done high; the receiver cannot hold results off, so
// capture them when done is high. The pipeline runs the edge, cross product
// and dot product math, then the restoring divider (one quotient bit per
// stage: 16 integer bits, 16 fraction bits and a rounding bit), then
// rounding, the direction times t multiply and the hit point sum. On a miss
// (zero determinant, or the point outside the triangle) hit is low and
// distance and hit_point are zero. A negative t still counts as a hit.
// distance is t in Q16.16, rounded half away from zero and clamped;
// hit_point is o + d*t rounded half up to Q8.8 and clamped per component.
module ray_triangle_intersect
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rti_pkg::query_t  query,
    output logic                  done,
    output rti_pkg::result_t      result
);

    logic          stage_valid [rti_pkg::DIV_STEPS + 1];
    rti_pkg::div_t stage_word  [rti_pkg::DIV_STEPS + 1];

    // Never stall: every stage advances every cycle.
    assign busy = 1'b0;

    rti_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start && !busy),
        .query_in  (query),
        .valid_out (stage_valid[0]),
        .div_out   (stage_word[0])
    );

    // Chain of divider steps, one quotient bit each.
    for (genvar g = 0; g < rti_pkg::DIV_STEPS; g++)
    begin : g_div
        rti_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[g]),
            .div_in    (stage_word[g]),
            .valid_out (stage_valid[g+1]),
            .div_out   (stage_word[g+1])
        );
    end

    rti_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (stage_valid[rti_pkg::DIV_STEPS]),
        .div_in   (stage_word[rti_pkg::DIV_STEPS]),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ hdl/rti_checker.sv @@
// Port-level checker for the ray-triangle intersection block, with its bind.
`default_nettype none
`include "ray_triangle_intersect_macros.svh"

module rti_checker
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire rti_pkg::result_t result
);

    logic [5:0] since_reg;
    logic [5:0] since_next;
    logic       settled;

    // Count cycles since reset, holding at the pipeline latency.
    assign settled    = since_reg >= 6'(rti_pkg::LATENCY);
    assign since_next = settled ? since_reg : since_reg + 6'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg <= '0;
        end
        else
        begin
            since_reg <= since_next;
        end
    end

    `RTI_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `RTI_ASSERT_IMPLY(a_miss_zero, clk, rst_n, done && !result.hit, result.distance == '0 && result.hit_point == '0)
    `RTI_ASSERT_IMPLY(a_latency, clk, rst_n, settled, done == $past(start && !busy, rti_pkg::LATENCY))
    `RTI_ASSERT_IMPLY(a_no_early_done, clk, rst_n, since_reg < 6'd6, !done)

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
